// File: hw/rtl/lmc_pkg.sv
package lmc_pkg;

  localparam int unsigned NumBcdDigits  = 20;
  localparam int unsigned BcdWidth      = NumBcdDigits * 4;
  localparam int unsigned InWidth       = 64;
  localparam int unsigned BitsPerStep   = 4;
  localparam int unsigned CntWidth      = 4;
  localparam int unsigned LenWidth      = 5;

  localparam logic [LenWidth-1:0] LenShort  = 5'd13;
  localparam logic [LenWidth-1:0] LenMid    = 5'd15;
  localparam logic [LenWidth-1:0] LenLong   = 5'd16;

  localparam logic [1:0] ClassInvalid = 2'd0;
  localparam logic [1:0] ClassPfx3x   = 2'd1;
  localparam logic [1:0] ClassPfx5x   = 2'd2;
  localparam logic [1:0] ClassPfx4    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic conv_en;
    logic scan_en;
  } cmd_t;

  typedef struct packed {
    logic cnt_done;
  } sts_t;

endpackage

// File: hw/rtl/lmc_datapath.sv
module lmc_datapath
  import lmc_pkg::*;
(
  input  logic                clk,
  input  cmd_t                cmd,
  input  logic [InWidth-1:0]  in_card_number,
  output sts_t                sts,
  output logic [1:0]          card_class
);

  logic [InWidth-1:0]  bin_r, bin_nxt;
  logic [BcdWidth-1:0] bcd_r, bcd_nxt;
  logic [CntWidth-1:0] cnt_r, cnt_nxt;
  logic                neg_r, neg_nxt;
  logic [3:0]          acc_r, acc_nxt;
  logic [LenWidth-1:0] len_r, len_nxt;
  logic [3:0]          lead_r, lead_nxt;
  logic [3:0]          second_r, second_nxt;
  logic [3:0]          prev_r, prev_nxt;

  logic [BcdWidth-1:0] dd_bcd;
  logic [InWidth-1:0]  dd_bin;
  logic [3:0]          dig;
  logic [4:0]          dbl;
  logic [3:0]          dval;
  logic [4:0]          sum;

  // shift-and-add-3 conversion, four bits per cycle
  always_comb begin
    dd_bcd = bcd_r;
    dd_bin = bin_r;
    for (int b = 0; b < BitsPerStep; b++) begin
      for (int k = 0; k < NumBcdDigits; k++) begin
        if (dd_bcd[k*4 +: 4] >= 4'd5) begin
          dd_bcd[k*4 +: 4] = dd_bcd[k*4 +: 4] + 4'd3;
        end
      end
      dd_bcd = {dd_bcd[BcdWidth-2:0], dd_bin[InWidth-1]};
      dd_bin = {dd_bin[InWidth-2:0], 1'b0};
    end
  end

  // Luhn digit weight: double every second digit from the right (odd zero-based positions), fold to one digit
  always_comb begin
    dig = bcd_r[3:0];
    dbl = {dig, 1'b0};
    if (cnt_r[0]) begin
      dval = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
    end else begin
      dval = dig;
    end
    sum = {1'b0, acc_r} + {1'b0, dval};
  end

  always_comb begin
    bin_nxt    = bin_r;
    bcd_nxt    = bcd_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    len_nxt    = len_r;
    lead_nxt   = lead_r;
    second_nxt = second_r;
    prev_nxt   = prev_r;
    if (cmd.load) begin
      bin_nxt    = in_card_number;
      bcd_nxt    = '0;
      cnt_nxt    = '0;
      neg_nxt    = in_card_number[InWidth-1];
      acc_nxt    = '0;
      len_nxt    = '0;
      lead_nxt   = '0;
      second_nxt = '0;
      prev_nxt   = '0;
    end else if (cmd.conv_en) begin
      bin_nxt = dd_bin;
      bcd_nxt = dd_bcd;
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.scan_en) begin
      bcd_nxt  = {4'd0, bcd_r[BcdWidth-1:4]};
      cnt_nxt  = cnt_r + 1'b1;
      acc_nxt  = (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
      prev_nxt = dig;
      if (dig != 4'd0) begin
        len_nxt    = {1'b0, cnt_r} + 1'b1;
        lead_nxt   = dig;
        second_nxt = prev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r    <= bin_nxt;
    bcd_r    <= bcd_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    acc_r    <= acc_nxt;
    len_r    <= len_nxt;
    lead_r   <= lead_nxt;
    second_r <= second_nxt;
    prev_r   <= prev_nxt;
  end

  assign sts.cnt_done = (cnt_r == {CntWidth{1'b1}});

  // after the scan, bcd_r[15:0] holds the digits above position sixteen
  always_comb begin
    card_class = ClassInvalid;
    if (!neg_r && (bcd_r[15:0] == 16'd0) && (acc_r == 4'd0)) begin
      if (lead_r == 4'd4) begin
        if (len_r == LenShort || len_r == LenLong) begin
          card_class = ClassPfx4;
        end
      end else if (lead_r == 4'd3 && (second_r == 4'd4 || second_r == 4'd7)) begin
        if (len_r == LenMid) begin
          card_class = ClassPfx3x;
        end
      end else if (lead_r == 4'd5 && second_r >= 4'd1 && second_r <= 4'd5) begin
        if (len_r == LenLong) begin
          card_class = ClassPfx5x;
        end
      end
    end
  end

endmodule

// File: hw/rtl/lmc_ctrl.sv
module lmc_ctrl
  import lmc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts.cnt_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.cnt_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CONV: cmd.conv_en = 1'b1;
      ST_SCAN: cmd.scan_en = 1'b1;
      ST_DONE: done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/luhn_card_number_classifier_unit.sv
// The class word is strobed on out_valid after start is taken, once the binary-to-decimal
//   conversion (four bits per cycle) and then the Luhn scan (one digit per cycle) have run;
//   a new card number is taken only once the controller is back in idle.
// Reset: synchronous active-low rst_n returns the controller to idle; no result is pending.
// The receiver cannot stall: each result is valid for exactly one cycle.
module luhn_card_number_classifier_unit
  import lmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [InWidth-1:0] in_card_number,
  output logic               out_valid,
  output logic [1:0]         out_card_class
);

  cmd_t       cmd;
  sts_t       sts;
  logic [1:0] card_class;

  lmc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  lmc_datapath u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .in_card_number (in_card_number),
    .sts            (sts),
    .card_class     (card_class)
  );

  assign out_card_class = card_class;

`ifndef SYNTHESIS
  a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe while idle");

  a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("not idle after result");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid)) else $error("accept did not start work");

  a_neg_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_card_number[InWidth-1]) |->
      ##33 (out_valid && out_card_class == ClassInvalid))
    else $error("negative number not invalid");
`endif

endmodule
